### design/nba_pkg.sv
package nba_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W   = $clog2(MAX_WIDTH);        // line-buffer address
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);   // row counter, holds the height
    localparam int CFG_W   = 11;                       // config data width
    localparam int CFG_IDX_W = 2;
    localparam int POS_W   = 10;                       // result coordinate width
    localparam int CODE_W  = 4;
    localparam int SHEET_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

    // Tile request handed from the front end to the mask stage.
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             mid_sel;   // line buffer holding the center row
        logic             up_en;
        logic             right_en;
        logic             left_en;
        logic             down;
        logic             last;
    } tile_req_t;

endpackage

### design/nba_line_ram.sv
module nba_line_ram
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [nba_pkg::COL_W-1:0]  wr_addr,
    input  logic                       wr_data,
    input  logic                       rd_en,
    input  logic [nba_pkg::COL_W-1:0]  rd_addr0,
    input  logic [nba_pkg::COL_W-1:0]  rd_addr1,
    output logic                       rd_data0,
    output logic                       rd_data1
);

    logic mem [nba_pkg::MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-first: a read at the written address returns the old bit
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data0 <= mem[rd_addr0];
            rd_data1 <= mem[rd_addr1];
        end
    end

endmodule

### design/nba_ctrl.sv
module nba_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           pixel_solid,
    input  logic                           is_flush,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nba_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           pipe_ready,
    output logic                           rd_en,
    output logic [nba_pkg::COL_W-1:0]      rd_addr0,
    output logic [nba_pkg::COL_W-1:0]      rd_addr1,
    output logic                           wr_en0,
    output logic                           wr_en1,
    output logic [nba_pkg::COL_W-1:0]      wr_addr,
    output logic                           wr_data,
    output nba_pkg::tile_req_t             req
);

    logic [nba_pkg::COL_W-1:0] wlast_reg, wlast_next;
    logic [nba_pkg::ROW_W-1:0] height_reg, height_next;
    logic [nba_pkg::COL_W-1:0] col_reg, col_next;
    logic [nba_pkg::ROW_W-1:0] row_reg, row_next;

    logic accept;
    logic in_frame;
    logic ignored;
    logic produce;
    logic col_end;

    assign in_ready  = pipe_ready;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid & pipe_ready;

    assign in_frame = (row_reg != height_reg);
    assign ignored  = in_frame ? is_flush : ~is_flush;
    assign produce  = ~ignored & (~in_frame | (row_reg != '0));
    assign col_end  = (col_reg == wlast_reg);

    // row r writes buffer r[0]; that buffer still holds row r-2 (the up row)
    assign rd_en    = accept;
    assign rd_addr0 = col_reg;
    assign rd_addr1 = col_reg + 1'b1;
    assign wr_addr  = col_reg;
    assign wr_data  = pixel_solid;
    assign wr_en0   = accept & in_frame & ~is_flush & ~row_reg[0];
    assign wr_en1   = accept & in_frame & ~is_flush & row_reg[0];

    always_comb
    begin
        req.valid    = in_valid & produce;
        req.col      = col_reg;
        req.row      = nba_pkg::POS_W'(row_reg - 1'b1);
        req.mid_sel  = ~row_reg[0];
        req.up_en    = (row_reg >= nba_pkg::ROW_W'(2));
        req.right_en = ~col_end;
        req.left_en  = (col_reg != '0);
        req.down     = in_frame & pixel_solid;
        req.last     = ~in_frame & col_end;
    end

    always_comb
    begin
        wlast_next  = wlast_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                nba_pkg::REG_MAP_WIDTH:
                begin
                    if (cfg_data == '0)
                        wlast_next = '0;
                    else if (32'(cfg_data) > nba_pkg::MAX_WIDTH)
                        wlast_next = nba_pkg::COL_W'(nba_pkg::MAX_WIDTH - 1);
                    else
                        wlast_next = nba_pkg::COL_W'(cfg_data - 1'b1);
                    col_next = '0;
                    row_next = '0;
                end
                nba_pkg::REG_MAP_HEIGHT:
                begin
                    if (cfg_data == '0)
                        height_next = nba_pkg::ROW_W'(1);
                    else if (32'(cfg_data) > nba_pkg::MAX_HEIGHT)
                        height_next = nba_pkg::ROW_W'(nba_pkg::MAX_HEIGHT);
                    else
                        height_next = nba_pkg::ROW_W'(cfg_data);
                    col_next = '0;
                    row_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept && !ignored)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = in_frame ? row_reg + 1'b1 : '0;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg  <= nba_pkg::COL_W'(nba_pkg::MAX_WIDTH - 1);
            height_reg <= nba_pkg::ROW_W'(nba_pkg::MAX_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            wlast_reg  <= wlast_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

### design/nba_tile.sv
module nba_tile
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  nba_pkg::tile_req_t            req,
    output logic                          pipe_ready,
    input  logic                          buf0_rd0,
    input  logic                          buf0_rd1,
    input  logic                          buf1_rd0,
    input  logic                          buf1_rd1,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nba_pkg::POS_W-1:0]     tile_column,
    output logic [nba_pkg::POS_W-1:0]     tile_row,
    output logic                          tile_present,
    output logic [nba_pkg::CODE_W-1:0]    tile_code,
    output logic [nba_pkg::SHEET_W-1:0]   sheet_x,
    output logic [nba_pkg::SHEET_W-1:0]   sheet_y,
    output logic                          frame_last
);

    nba_pkg::tile_req_t s1_reg;
    logic               s1_valid_reg;
    logic               prev_center_reg;
    logic               out_valid_reg;

    logic                        advance;
    logic                        center;
    logic                        up;
    logic                        right;
    logic                        left;
    logic [nba_pkg::CODE_W-1:0]  code;

    logic [nba_pkg::POS_W-1:0]   col_reg;
    logic [nba_pkg::POS_W-1:0]   row_reg;
    logic                        present_reg;
    logic [nba_pkg::CODE_W-1:0]  code_reg;
    logic                        last_reg;

    assign advance    = ~out_valid_reg | out_ready;
    assign pipe_ready = ~s1_valid_reg | advance;

    always_comb
    begin
        center = s1_reg.mid_sel ? buf1_rd0 : buf0_rd0;
        right  = s1_reg.right_en & (s1_reg.mid_sel ? buf1_rd1 : buf0_rd1);
        up     = s1_reg.up_en & (s1_reg.mid_sel ? buf0_rd0 : buf1_rd0);
        left   = s1_reg.left_en & prev_center_reg;
        code   = center ? {left, s1_reg.down, right, up} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            prev_center_reg <= 1'b0;
        end
        else
        begin
            if (pipe_ready)
                s1_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
            if (advance && s1_valid_reg)
                prev_center_reg <= center;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_ready)
            s1_reg <= req;
        if (advance && s1_valid_reg)
        begin
            col_reg     <= nba_pkg::POS_W'(s1_reg.col);
            row_reg     <= s1_reg.row;
            present_reg <= center;
            code_reg    <= code;
            last_reg    <= s1_reg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tile_column  = col_reg;
    assign tile_row     = row_reg;
    assign tile_present = present_reg;
    assign tile_code    = code_reg;
    assign sheet_x      = {code_reg[1:0], 4'b0000};
    assign sheet_y      = {code_reg[3:2], 4'b0000};
    assign frame_last   = last_reg;

endmodule

### design/neighbor_bitmask_autotiler.sv
// Pipeline: a word's result (if any) passes the mask-stage and output registers.
// Throughput: one word per cycle, set by the two line-buffer RAMs (one write and
//   two reads each per cycle) and their registered read, if out_ready keeps up.
// Reset (rst_n, async, active low): width and height 1024, position row 0 col 0,
//   pipeline empty. Line buffers are not cleared; each entry is written before use.
module neighbor_bitmask_autotiler
(
    input  logic                           clk,
    input  logic                           rst_n,
    // pixel stream
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           pixel_solid,
    input  logic                           is_flush,
    // tile results
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [nba_pkg::POS_W-1:0]      tile_column,
    output logic [nba_pkg::POS_W-1:0]      tile_row,
    output logic                           tile_present,
    output logic [nba_pkg::CODE_W-1:0]     tile_code,
    output logic [nba_pkg::SHEET_W-1:0]    sheet_x,
    output logic [nba_pkg::SHEET_W-1:0]    sheet_y,
    output logic                           frame_last,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nba_pkg::CFG_W-1:0]      cfg_data
);

    // Two 1-bit line buffers used ping-pong by row parity: row r writes its
    // pixels into buffer r[0], whose old contents are row r-2 (the up row),
    // while buffer ~r[0] holds row r-1 (center and right neighbor).
    // Writes happen at accept time; read-first RAMs hand back the old bit.

    logic                      pipe_ready;
    logic                      rd_en;
    logic [nba_pkg::COL_W-1:0] rd_addr0;
    logic [nba_pkg::COL_W-1:0] rd_addr1;
    logic                      wr_en0;
    logic                      wr_en1;
    logic [nba_pkg::COL_W-1:0] wr_addr;
    logic                      wr_data;
    nba_pkg::tile_req_t        req;

    logic buf0_rd0;
    logic buf0_rd1;
    logic buf1_rd0;
    logic buf1_rd1;

    nba_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_solid (pixel_solid),
        .is_flush    (is_flush),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pipe_ready  (pipe_ready),
        .rd_en       (rd_en),
        .rd_addr0    (rd_addr0),
        .rd_addr1    (rd_addr1),
        .wr_en0      (wr_en0),
        .wr_en1      (wr_en1),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .req         (req)
    );

    nba_line_ram u_buf0
    (
        .clk      (clk),
        .wr_en    (wr_en0),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (buf0_rd0),
        .rd_data1 (buf0_rd1)
    );

    nba_line_ram u_buf1
    (
        .clk      (clk),
        .wr_en    (wr_en1),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (buf1_rd0),
        .rd_data1 (buf1_rd1)
    );

    // mask stage plus output register
    nba_tile u_tile
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .pipe_ready   (pipe_ready),
        .buf0_rd0     (buf0_rd0),
        .buf0_rd1     (buf0_rd1),
        .buf1_rd0     (buf1_rd0),
        .buf1_rd1     (buf1_rd1),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tile_column  (tile_column),
        .tile_row     (tile_row),
        .tile_present (tile_present),
        .tile_code    (tile_code),
        .sheet_x      (sheet_x),
        .sheet_y      (sheet_y),
        .frame_last   (frame_last)
    );

endmodule

### tb/sv/neighbor_bitmask_autotiler_checker.sv
module neighbor_bitmask_autotiler_checker
    import nba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 pixel_solid,
    input  logic                 is_flush,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [POS_W-1:0]     tile_column,
    input  logic [POS_W-1:0]     tile_row,
    input  logic                 tile_present,
    input  logic [CODE_W-1:0]    tile_code,
    input  logic [SHEET_W-1:0]   sheet_x,
    input  logic [SHEET_W-1:0]   sheet_y,
    input  logic                 frame_last,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatch_count,
    output int                   tiles_due
);

    typedef struct packed {
        logic [POS_W-1:0]   column;
        logic [POS_W-1:0]   row;
        logic               present;
        logic [CODE_W-1:0]  code;
        logic [SHEET_W-1:0] sheet_x;
        logic [SHEET_W-1:0] sheet_y;
        logic               last;
    } tile_t;

    // register copies (raw, clamped on use)
    logic [CFG_W-1:0] width_raw  = 11'd1024;
    logic [CFG_W-1:0] height_raw = 11'd1024;

    // row buffers: middle holds the row above the incoming pixel, upper the one above that
    bit upper_row_buf  [MAX_WIDTH];
    bit middle_row_buf [MAX_WIDTH];

    int unsigned next_col   = 0;
    int unsigned next_row   = 0;
    bit          left_solid = 1'b0;   // center of the previous column, already overwritten

    tile_t pending_tiles [$];

    function automatic int unsigned effective_dim(input logic [CFG_W-1:0] v,
                                                  input int unsigned limit);
        if (v == '0)
        begin
            return 1;
        end
        if (v > limit)
        begin
            return limit;
        end
        return v;
    endfunction

    function automatic tile_t make_tile(input int unsigned col, input int unsigned row,
                                        input bit center, input bit up, input bit right,
                                        input bit down, input bit left, input bit last);
        tile_t t;
        t.column  = col[POS_W-1:0];
        t.row     = row[POS_W-1:0];
        t.present = center;
        t.code    = center ? {left, down, right, up} : '0;
        t.sheet_x = {t.code[1:0], 4'b0000};
        t.sheet_y = {t.code[3:2], 4'b0000};
        t.last    = last;
        return t;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            REG_MAP_WIDTH:  width_raw = data;
            REG_MAP_HEIGHT: height_raw = data;
            default:        return;
        endcase
        next_col   = 0;
        next_row   = 0;
        left_solid = 1'b0;
    endfunction

    // One accepted word in, at most one tile out.
    function automatic bit predict_tile(input bit solid, input bit flush, output tile_t t);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        bit          center;
        bit          up;
        bit          right;
        bit          made;
        w    = effective_dim(width_raw, MAX_WIDTH);
        h    = effective_dim(height_raw, MAX_HEIGHT);
        t    = '0;
        made = 1'b0;
        c    = next_col;
        if (c >= w || next_row > h)
        begin
            next_col   = 0;
            next_row   = 0;
            left_solid = 1'b0;
            c          = 0;
        end
        if (c == 0)
        begin
            left_solid = 1'b0;
        end
        if (next_row < h)
        begin
            if (flush)
            begin
                return 1'b0;
            end
            if (next_row >= 1)
            begin
                center = middle_row_buf[c];
                up     = (next_row >= 2) ? upper_row_buf[c] : 1'b0;
                right  = (c + 1 < w) ? middle_row_buf[c + 1] : 1'b0;
                t      = make_tile(c, next_row - 1, center, up, right, solid, left_solid, 1'b0);
                made   = 1'b1;
                upper_row_buf[c] = center;
                left_solid       = center;
            end
            middle_row_buf[c] = solid;
        end
        else
        begin
            if (!flush)
            begin
                return 1'b0;
            end
            center = middle_row_buf[c];
            up     = (h >= 2) ? upper_row_buf[c] : 1'b0;
            right  = (c + 1 < w) ? middle_row_buf[c + 1] : 1'b0;
            t      = make_tile(c, h - 1, center, up, right, 1'b0, left_solid, c + 1 == w);
            made   = 1'b1;
            left_solid = center;
        end
        next_col = c + 1;
        if (next_col >= w)
        begin
            next_col   = 0;
            left_solid = 1'b0;
            if (next_row >= h)
            begin
                next_row = 0;
            end
            else
            begin
                next_row = next_row + 1;
            end
        end
        return made;
    endfunction

    task automatic report(input string msg);
        if (mismatch_count < 40)
        begin
            $display("[%0t] tile mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] seen,
                               input logic [15:0] want, input tile_t at);
        if (seen !== want)
        begin
            report($sformatf("(%0d,%0d) %s got %0d want %0d",
                             at.column, at.row, name, seen, want));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tile_t want;
        tile_t fresh;
        if (!rst_n)
        begin
            width_raw      = 11'd1024;
            height_raw     = 11'd1024;
            next_col       = 0;
            next_row       = 0;
            left_solid     = 1'b0;
            mismatch_count = 0;
            pending_tiles.delete();
            tiles_due      = 0;
        end
        else
        begin
            // compare before queuing: a word taken now cannot be answered in the same cycle
            if (out_valid && out_ready)
            begin
                if (pending_tiles.size() == 0)
                begin
                    report($sformatf("unexpected word at (%0d,%0d)", tile_column, tile_row));
                end
                else
                begin
                    want = pending_tiles.pop_front();
                    check_field("tile_column", tile_column, want.column, want);
                    check_field("tile_row", tile_row, want.row, want);
                    check_field("tile_present", tile_present, want.present, want);
                    check_field("tile_code", tile_code, want.code, want);
                    check_field("sheet_x", sheet_x, want.sheet_x, want);
                    check_field("sheet_y", sheet_y, want.sheet_y, want);
                    check_field("frame_last", frame_last, want.last, want);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                if (predict_tile(pixel_solid, is_flush, fresh))
                begin
                    pending_tiles.push_back(fresh);
                end
            end
            tiles_due = pending_tiles.size();
        end
    end

endmodule

### tb/sv/neighbor_bitmask_autotiler_tb.sv
module neighbor_bitmask_autotiler_tb;
    import nba_pkg::*;

    // indexes past the register list; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int GAP_MAX       = 16;       // longest idle draw per word, both sides
    localparam int RANDOM_WORDS  = 450;      // map words in the random part
    localparam int SETTLE_CYCLES = 8;        // margin after the drain for words that make no tile
    localparam int HOLD_AFTER    = 600;      // result count that starts the long back-pressure
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 pixel_solid = 1'b0;
    logic                 is_flush    = 1'b0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [POS_W-1:0]     tile_column;
    logic [POS_W-1:0]     tile_row;
    logic                 tile_present;
    logic [CODE_W-1:0]    tile_code;
    logic [SHEET_W-1:0]   sheet_x;
    logic [SHEET_W-1:0]   sheet_y;
    logic                 frame_last;
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 cfg_ready;

    int mismatch_count;
    int tiles_due;

    bit tight_mode = 1'b0;   // when set, neither side idles
    int map_words  = 0;      // pixel and flush words that the block acts on

    neighbor_bitmask_autotiler dut (.*);

    neighbor_bitmask_autotiler_checker tile_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap();
        if (tight_mode)
        begin
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    // A dimension of 1 may also be written as 0, which the block reads as 1.
    function automatic logic [CFG_W-1:0] dim_word(input int eff);
        if (eff == 1 && $urandom_range(0, 1) == 1)
        begin
            return '0;
        end
        return CFG_W'(eff);
    endfunction

    // Offer one word after a random gap and hold it until taken.
    // Called at a rising edge; returns at the edge that took the word.
    task automatic send_word(input logic solid, input logic flush);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_solid <= solid;
        is_flush    <= flush;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop offering, let every expected tile drain, then give the block a few more
    // cycles for words that make no tile (row 0, ignored words).
    task automatic pause_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (tiles_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; 'more' keeps cfg_valid up for a write that follows at once.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                             input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (!more)
        begin
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic set_map(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        pause_idle();
        reg_write(REG_MAP_WIDTH, w_raw, 1'b1);
        reg_write(REG_MAP_HEIGHT, h_raw, 1'b0);
    endtask

    // One map in raster order, then one flush per column. Now and then a stray word
    // goes in that the block must ignore: a flush inside the map, a pixel in the drain.
    // A cut at word n abandons the frame there; the caller then restarts it.
    task automatic stream_frame(input int w, input int h, input int cut, input int density);
        int n;
        int r;
        int c;
        n = 0;
        for (r = 0; r < h; r++)
        begin
            for (c = 0; c < w; c++)
            begin
                if (n == cut)
                begin
                    return;
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    send_word(1'($urandom_range(0, 1)), 1'b1);
                end
                send_word($urandom_range(0, 99) < density, 1'b0);
                n++;
                map_words++;
            end
        end
        for (c = 0; c < w; c++)
        begin
            if (n == cut)
            begin
                return;
            end
            if ($urandom_range(0, 39) == 0)
            begin
                send_word(1'($urandom_range(0, 1)), 1'b0);
            end
            send_word(1'($urandom_range(0, 1)), 1'b1);
            n++;
            map_words++;
        end
    endtask

    // Result side: random ready gaps per word, plus one long hold-off once the
    // stream is well under way, so the pipeline backs up into in_ready.
    initial
    begin : result_sink
        int wait_left;
        int hold_left;
        int words_taken;
        wait_left   = 0;
        hold_left   = 0;
        words_taken = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                words_taken++;
                wait_left = draw_gap();
                if (words_taken == HOLD_AFTER)
                begin
                    hold_left = HOLD_CYCLES;
                end
            end
            else if (!out_ready && wait_left > 0)
            begin
                wait_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
            end
            out_ready <= (wait_left == 0) && (hold_left == 0);
        end
    end

    initial
    begin : stimulus
        int cur_w;
        int cur_h;
        int cut;
        int pick;
        int words_at_start;
        bit need_dims;
        int i;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: 3x2 map ---
        // stray flush inside the map, a spare-index write mid-frame (no restart),
        // stray pixel in the drain, last flush carries frame_last
        set_map(11'd3, 11'd2);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b1);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b0);
        pause_idle();
        reg_write(REG_SPARE_3, 11'h7FF, 1'b0);
        for (i = 0; i < 3; i++)
        begin
            send_word(1'b1, 1'b0);
        end
        send_word(1'b1, 1'b0);
        for (i = 0; i < 3; i++)
        begin
            send_word(1'b0, 1'b1);
        end

        // --- directed: restart mid-frame, then a solid 3x3 (center gets all four) ---
        set_map(11'd3, 11'd3);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        pause_idle();
        reg_write(REG_MAP_HEIGHT, 11'd3, 1'b0);
        for (i = 0; i < 9; i++)
        begin
            send_word(1'b1, 1'b0);
        end
        for (i = 0; i < 3; i++)
        begin
            send_word(1'b0, 1'b1);
        end

        // --- tallest map, one column: height over range clamps, width 0 acts as 1 ---
        set_map(11'd0, 11'd2047);
        stream_frame(1, MAX_HEIGHT, -1, 50);

        // --- random small maps ---
        cur_w = $urandom_range(1, 12);
        cur_h = $urandom_range(1, 8);
        set_map(dim_word(cur_w), dim_word(cur_h));
        need_dims      = 1'b0;
        words_at_start = map_words;
        while (map_words - words_at_start < RANDOM_WORDS)
        begin
            tight_mode <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                pause_idle();
                reg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_W'($urandom_range(0, 2047)), 1'b0);
            end
            if (need_dims || $urandom_range(0, 9) < 6)
            begin
                // 0: width only, 1: height only, 2: both
                pick = $urandom_range(0, 2);
                pause_idle();
                if (pick != 1)
                begin
                    cur_w = $urandom_range(1, 12);
                    reg_write(REG_MAP_WIDTH, dim_word(cur_w), pick == 2);
                end
                if (pick != 0)
                begin
                    cur_h = $urandom_range(1, 8);
                    reg_write(REG_MAP_HEIGHT, dim_word(cur_h), 1'b0);
                end
            end
            // else the next frame follows straight on from the last drain
            cut = -1;
            if ($urandom_range(0, 7) == 0)
            begin
                cut = $urandom_range(0, cur_w * cur_h + cur_w - 1);
            end
            need_dims = (cut >= 0);
            stream_frame(cur_w, cur_h, cut, $urandom_range(20, 80));
        end

        pause_idle();
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d tiles outstanding", CYCLE_LIMIT, tiles_due);
        $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
design/nba_pkg.sv
design/nba_line_ram.sv
design/nba_ctrl.sv
design/nba_tile.sv
design/neighbor_bitmask_autotiler.sv
tb/sv/neighbor_bitmask_autotiler_checker.sv
tb/sv/neighbor_bitmask_autotiler_tb.sv
